// File: rtl/shani_pkg.sv
package shani_pkg;

	// opcode values
	localparam logic [2:0] OP_SHA1RNDS4   = 3'd0;
	localparam logic [2:0] OP_SHA1NEXTE   = 3'd1;
	localparam logic [2:0] OP_SHA1MSG1    = 3'd2;
	localparam logic [2:0] OP_SHA1MSG2    = 3'd3;
	localparam logic [2:0] OP_SHA256RNDS2 = 3'd4;
	localparam logic [2:0] OP_SHA256MSG1  = 3'd5;
	localparam logic [2:0] OP_SHA256MSG2  = 3'd6;
	localparam logic [2:0] OP_UNDEF       = 3'd7;

	// sha1rnds4 function select codes
	localparam logic [1:0] SEL_CH   = 2'd0;
	localparam logic [1:0] SEL_PAR1 = 2'd1;
	localparam logic [1:0] SEL_MAJ  = 2'd2;
	localparam logic [1:0] SEL_PAR3 = 2'd3;

	localparam logic [31:0] SHA1_K0 = 32'h5A827999;
	localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

	// working words carried down the pipeline
	typedef struct packed {
		logic [2:0]       op;
		logic [1:0]       sel;
		logic [7:0][31:0] x;
		logic [31:0]      k;
	} shani_data_t;

	typedef struct packed {
		logic [31:0] a, b, c, d, e;
	} shani_sha1_t;

	typedef struct packed {
		logic [31:0] a, b, c, d, e, f, g, h;
	} shani_sha256_t;

	function automatic logic [31:0] sha1_f(input logic [1:0] sel, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] r;
		case (sel)
			SEL_CH:  r = (b & c) ^ (~b & d);
			SEL_MAJ: r = (b & c) ^ (b & d) ^ (c & d);
			default: r = b ^ c ^ d;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sha1_k(input logic [1:0] sel);
		logic [31:0] r;
		case (sel)
			SEL_CH:   r = SHA1_K0;
			SEL_PAR1: r = SHA1_K1;
			SEL_MAJ:  r = SHA1_K2;
			SEL_PAR3: r = SHA1_K3;
			default:  r = SHA1_K3;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rol1(input logic [31:0] v);
		return {v[30:0], v[31]};
	endfunction

	function automatic logic [31:0] rol30(input logic [31:0] v);
		return {v[1:0], v[31:2]};
	endfunction

	// one sha1 round
	function automatic shani_sha1_t sha1_round(input logic [1:0] sel, input shani_sha1_t s,
			input logic [31:0] w);
		shani_sha1_t n;
		n.a = sha1_f(sel, s.b, s.c, s.d) + {s.a[26:0], s.a[31:27]} + w + s.e + sha1_k(sel);
		n.b = s.a;
		n.c = rol30(s.b);
		n.d = s.c;
		n.e = s.d;
		return n;
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	// one sha256 round
	function automatic shani_sha256_t sha256_round(input shani_sha256_t s,
			input logic [31:0] wk);
		shani_sha256_t n;
		logic [31:0] t1, t2;
		t1 = ((s.e & s.f) ^ (~s.e & s.g)) + big_s1(s.e) + wk + s.h;
		t2 = ((s.a & s.b) ^ (s.a & s.c) ^ (s.b & s.c)) + big_s0(s.a);
		n.h = s.g;
		n.g = s.f;
		n.f = s.e;
		n.e = t1 + s.d;
		n.d = s.c;
		n.c = s.b;
		n.b = s.a;
		n.a = t1 + t2;
		return n;
	endfunction

endpackage

// File: rtl/sha_ni_execution_unit.sv
// sha extension execution unit, four register stages
// an accepted input passes through data_s1, data_s2, data_s3 and data_s4 in order, and
// out_valid is valid_s4; the four sha1rnds4 rounds are split one per stage
// throughput: one instruction per cycle; a stalled stage holds its item and backs up
// the stages behind it, in_ready drops only when all four stages are full
// reset: arst_n clears the stage valid bits asynchronously, data registers are not reset
module sha_ni_execution_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [1:0]  round_func_sel,
	input  logic [31:0] first_word0,
	input  logic [31:0] first_word1,
	input  logic [31:0] first_word2,
	input  logic [31:0] first_word3,
	input  logic [31:0] second_word0,
	input  logic [31:0] second_word1,
	input  logic [31:0] second_word2,
	input  logic [31:0] second_word3,
	input  logic [31:0] round_key_lo,
	input  logic [31:0] round_key_hi,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_word0,
	output logic [31:0] result_word1,
	output logic [31:0] result_word2,
	output logic [31:0] result_word3
);

	shani_pkg::shani_data_t front_d, mid_d, tail3_d, tail4_d;
	shani_pkg::shani_data_t data_s1, data_s2, data_s3, data_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	// stage enables: a stage loads when empty or when its item moves on
	assign en4 = !valid_s4 || out_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_ready = en1;

	shani_front u_front (
		.op             (op),
		.round_func_sel (round_func_sel),
		.src1           ({first_word3, first_word2, first_word1, first_word0}),
		.src2           ({second_word3, second_word2, second_word1, second_word0}),
		.round_key_lo   (round_key_lo),
		.round_key_hi   (round_key_hi),
		.data           (front_d)
	);

	shani_mid u_mid (
		.din  (data_s1),
		.dout (mid_d)
	);

	shani_sha1_tail u_tail3 (
		.din  (data_s2),
		.w    (data_s2.x[6]),
		.dout (tail3_d)
	);

	shani_sha1_tail u_tail4 (
		.din  (data_s3),
		.w    (data_s3.x[7]),
		.dout (tail4_d)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (en1) data_s1 <= front_d;
		if (en2) data_s2 <= mid_d;
		if (en3) data_s3 <= tail3_d;
		if (en4) data_s4 <= tail4_d;
	end

	assign out_valid    = valid_s4;
	assign result_word3 = data_s4.x[0];
	assign result_word2 = data_s4.x[1];
	assign result_word1 = data_s4.x[2];
	assign result_word0 = data_s4.x[3];

	// back-pressure only once every stage is occupied
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("in_ready low with an empty stage");

	// an accepted transfer always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted transfer lost at stage one");

	// the undefined opcode produces an all-zero result
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && data_s4.op == shani_pkg::OP_UNDEF) |->
		(result_word0 == 32'd0 && result_word1 == 32'd0 &&
		 result_word2 == 32'd0 && result_word3 == 32'd0))
		else $error("undefined opcode gave a non-zero result");

endmodule

// File: rtl/shani_front.sv
module shani_front (
	input  logic [2:0]           op,
	input  logic [1:0]           round_func_sel,
	input  logic [3:0][31:0]     src1,
	input  logic [3:0][31:0]     src2,
	input  logic [31:0]          round_key_lo,
	input  logic [31:0]          round_key_hi,
	output shani_pkg::shani_data_t data
);

	shani_pkg::shani_sha1_t   s1_in, s1_out;
	shani_pkg::shani_sha256_t s2_in, s2_out;
	logic [31:0]              w16;

	// first sha1 round and first sha256 round
	always_comb begin
		s1_in = '{a: src1[3], b: src1[2], c: src1[1], d: src1[0], e: 32'd0};
		s1_out = shani_pkg::sha1_round(round_func_sel, s1_in, src2[3]);
		s2_in = '{a: src2[3], b: src2[2], c: src1[3], d: src1[2],
			e: src2[1], f: src2[0], g: src1[1], h: src1[0]};
		s2_out = shani_pkg::sha256_round(s2_in, round_key_lo);
		w16 = shani_pkg::rol1(src1[3] ^ src2[2]);
	end

	// decode, the single-stage operations and the first step of the others
	always_comb begin
		data = '0;
		data.op = op;
		data.sel = round_func_sel;
		case (op)
			shani_pkg::OP_SHA1RNDS4: begin
				data.x[0] = s1_out.a;
				data.x[1] = s1_out.b;
				data.x[2] = s1_out.c;
				data.x[3] = s1_out.d;
				data.x[4] = s1_out.e;
				data.x[5] = src2[2];
				data.x[6] = src2[1];
				data.x[7] = src2[0];
			end
			shani_pkg::OP_SHA1NEXTE: begin
				data.x[0] = src2[3] + shani_pkg::rol30(src1[3]);
				data.x[1] = src2[2];
				data.x[2] = src2[1];
				data.x[3] = src2[0];
			end
			shani_pkg::OP_SHA1MSG1: begin
				data.x[0] = src1[1] ^ src1[3];
				data.x[1] = src1[0] ^ src1[2];
				data.x[2] = src2[3] ^ src1[1];
				data.x[3] = src2[2] ^ src1[0];
			end
			shani_pkg::OP_SHA1MSG2: begin
				data.x[0] = w16;
				data.x[1] = shani_pkg::rol1(src1[2] ^ src2[1]);
				data.x[2] = shani_pkg::rol1(src1[1] ^ src2[0]);
				data.x[3] = shani_pkg::rol1(src1[0] ^ w16);
			end
			shani_pkg::OP_SHA256RNDS2: begin
				data.x[0] = s2_out.a;
				data.x[1] = s2_out.b;
				data.x[2] = s2_out.c;
				data.x[3] = s2_out.d;
				data.x[4] = s2_out.e;
				data.x[5] = s2_out.f;
				data.x[6] = s2_out.g;
				data.x[7] = s2_out.h;
				data.k = round_key_hi;
			end
			shani_pkg::OP_SHA256MSG1: begin
				data.x[0] = src1[3] + shani_pkg::small_s0(src2[0]);
				data.x[1] = src1[2] + shani_pkg::small_s0(src1[3]);
				data.x[2] = src1[1] + shani_pkg::small_s0(src1[2]);
				data.x[3] = src1[0] + shani_pkg::small_s0(src1[1]);
			end
			shani_pkg::OP_SHA256MSG2: begin
				// w16 and w17 now, w18 and w19 in the next stage
				data.x[0] = src1[0] + shani_pkg::small_s1(src2[2]);
				data.x[1] = src1[1] + shani_pkg::small_s1(src2[3]);
				data.x[2] = src1[2];
				data.x[3] = src1[3];
			end
			default: begin
				data.x = '0;
			end
		endcase
	end

endmodule

// File: rtl/shani_mid.sv
module shani_mid (
	input  shani_pkg::shani_data_t din,
	output shani_pkg::shani_data_t dout
);

	shani_pkg::shani_sha1_t   s1_in, s1_out;
	shani_pkg::shani_sha256_t s2_in, s2_out;

	// second sha1 round and second sha256 round
	always_comb begin
		s1_in = '{a: din.x[0], b: din.x[1], c: din.x[2], d: din.x[3], e: din.x[4]};
		s1_out = shani_pkg::sha1_round(din.sel, s1_in, din.x[5]);
		s2_in = '{a: din.x[0], b: din.x[1], c: din.x[2], d: din.x[3],
			e: din.x[4], f: din.x[5], g: din.x[6], h: din.x[7]};
		s2_out = shani_pkg::sha256_round(s2_in, din.k);
	end

	// finish the two-stage operations and run the second sha1rnds4 round, results land in words 0 to 3
	always_comb begin
		dout = din;
		case (din.op)
			shani_pkg::OP_SHA1RNDS4: begin
				dout.x[0] = s1_out.a;
				dout.x[1] = s1_out.b;
				dout.x[2] = s1_out.c;
				dout.x[3] = s1_out.d;
				dout.x[4] = s1_out.e;
			end
			shani_pkg::OP_SHA256RNDS2: begin
				dout.x[0] = s2_out.a;
				dout.x[1] = s2_out.b;
				dout.x[2] = s2_out.e;
				dout.x[3] = s2_out.f;
			end
			shani_pkg::OP_SHA256MSG2: begin
				dout.x[0] = din.x[3] + shani_pkg::small_s1(din.x[1]);
				dout.x[1] = din.x[2] + shani_pkg::small_s1(din.x[0]);
				dout.x[2] = din.x[1];
				dout.x[3] = din.x[0];
			end
			default: begin
				dout = din;
			end
		endcase
	end

endmodule

// File: rtl/shani_sha1_tail.sv
module shani_sha1_tail (
	input  shani_pkg::shani_data_t din,
	input  logic [31:0]            w,
	output shani_pkg::shani_data_t dout
);

	shani_pkg::shani_sha1_t s_in, s_out;

	// one further sha1 round, other operations pass untouched
	always_comb begin
		s_in = '{a: din.x[0], b: din.x[1], c: din.x[2], d: din.x[3], e: din.x[4]};
		s_out = shani_pkg::sha1_round(din.sel, s_in, w);
		dout = din;
		if (din.op == shani_pkg::OP_SHA1RNDS4) begin
			dout.x[0] = s_out.a;
			dout.x[1] = s_out.b;
			dout.x[2] = s_out.c;
			dout.x[3] = s_out.d;
			dout.x[4] = s_out.e;
		end
	end

endmodule
